// ===== sv/acpr_pkg.sv =====
package acpr_pkg;

    // Table and search sizes
    localparam int MAX_BOXES  = 64;
    localparam int MAX_PASSES = 8;
    localparam int COORD_BITS = 32;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int PM_W    = COORD_W + 2;   // mover bound, centre +/- half extent
    localparam int SEP_W   = COORD_W + 3;   // separation between two bounds
    localparam int WIDE_W  = COORD_W + 4;   // centre plus separation before clamping

    localparam int IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W    = $clog2(MAX_BOXES + 1);
    localparam int PASS_W   = $clog2(MAX_PASSES + 1);
    localparam int SAT_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int BOX_W    = 6 * COORD_W;

    localparam int SEP_N = 6;
    localparam int SEL_W = 3;

    // Stream widths
    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USED_W = 3 * COORD_W + 6;

    // Command codes carried in s_tuser
    localparam logic [IN_USER_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [IN_USER_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [IN_USER_W-1:0] CMD_RESOLVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PREP,
        ST_SCAN,
        ST_PICK,
        ST_MOVE,
        ST_FINISH
    } acpr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic add;
        logic clear;
        logic prep;
        logic scan;
        logic pick;
        logic move;
        logic finish;
    } acpr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [IN_USER_W-1:0] command;
        logic                 count_zero;
        logic                 hit;
        logic                 last;
        logic                 pick_last;
        logic                 pass_last;
        logic                 out_free;
    } acpr_stat_t;

    // Clamp a wide signed value to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed((WIDE_W'(1) << (SAT_BITS - 1)) - WIDE_W'(1));
        lo = ~hi;
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/acpr_ram.sv =====
module acpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acpr_datapath.sv =====
module acpr_datapath import acpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  acpr_cmd_t             cmd,
    output acpr_stat_t            stat
);

    logic [IN_USER_W-1:0]      cmd_reg;
    logic signed [COORD_W-1:0] p_reg    [3];
    logic [HALF_W-1:0]         h_reg    [3];
    logic signed [PM_W-1:0]    pmin_reg [3];
    logic signed [PM_W-1:0]    pmax_reg [3];
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          addr_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      rd_vld_reg;
    logic signed [SEP_W-1:0]   sep_reg  [SEP_N];
    logic signed [SEP_W-1:0]   best_reg;
    logic [SEL_W-1:0]          pick_reg;
    logic [SEL_W-1:0]          k_reg;
    logic [PASS_W-1:0]         pass_reg;
    logic                      moved_reg;
    logic                      status_reg;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    logic signed [COORD_W-1:0] in_pos   [3];
    logic [HALF_W-1:0]         in_half  [3];
    logic signed [COORD_W-1:0] box_lo   [3];
    logic signed [COORD_W-1:0] box_hi   [3];
    logic signed [COORD_W-1:0] bmin     [3];
    logic signed [COORD_W-1:0] bmax     [3];
    logic [2:0]                ov;
    logic signed [SEP_W-1:0]   sep_now  [SEP_N];
    logic                      full;
    logic [BOX_W-1:0]          wr_data;
    logic [BOX_W-1:0]          rd_data;
    logic [1:0]                ax;
    logic signed [COORD_W-1:0] p_sel;
    logic signed [WIDE_W-1:0]  p_wide;
    logic signed [WIDE_W-1:0]  b_wide;
    logic signed [COORD_W-1:0] np;

    function automatic logic signed [WIDE_W-1:0] wide_c(input logic signed [COORD_W-1:0] v);
        return $signed({{(WIDE_W - COORD_W){v[COORD_W-1]}}, v});
    endfunction

    function automatic logic signed [WIDE_W-1:0] wide_h(input logic [HALF_W-1:0] v);
        return $signed({{(WIDE_W - HALF_W){1'b0}}, v});
    endfunction

    // Unpack the input beat
    assign in_pos[0]  = s_tdata[31:0];
    assign in_pos[1]  = s_tdata[63:32];
    assign in_pos[2]  = s_tdata[95:64];
    assign in_half[0] = s_tdata[126:96];
    assign in_half[1] = s_tdata[157:127];
    assign in_half[2] = s_tdata[188:158];

    assign full = (count_reg == CNT_W'(MAX_BOXES));

    // Stored bounds of a new box, and unpacking of the read word
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = sat_coord(wide_c(p_reg[a]) - wide_h(h_reg[a]));
            box_hi[a] = sat_coord(wide_c(p_reg[a]) + wide_h(h_reg[a]));
            wr_data[a*2*COORD_W +: COORD_W]           = box_lo[a];
            wr_data[a*2*COORD_W + COORD_W +: COORD_W] = box_hi[a];
            bmin[a] = rd_data[a*2*COORD_W +: COORD_W];
            bmax[a] = rd_data[a*2*COORD_W + COORD_W +: COORD_W];
        end
    end

    acpr_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .aclk  (aclk),
        .we    (cmd.add && !full),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_data),
        .re    (cmd.scan),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    // Strict overlap test and separations against the entry just read
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ov[a] = (pmin_reg[a] < PM_W'(wide_c(bmax[a])))
                 && (pmax_reg[a] > PM_W'(wide_c(bmin[a])));
            sep_now[2*a]   = SEP_W'(wide_c(bmax[a])) - SEP_W'(pmin_reg[a]);
            sep_now[2*a+1] = SEP_W'(pmax_reg[a]) - SEP_W'(wide_c(bmin[a]));
        end
    end

    // Push along the chosen direction and clamp
    always_comb begin
        ax     = pick_reg[2:1];
        p_sel  = p_reg[ax];
        p_wide = wide_c(p_sel);
        b_wide = $signed({{(WIDE_W - SEP_W){best_reg[SEP_W-1]}}, best_reg});
        np     = sat_coord(pick_reg[0] ? (p_wide - b_wide) : (p_wide + b_wide));
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.add && !full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.prep) begin
                rd_vld_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_vld_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_tuser;
            p_reg      <= in_pos;
            h_reg      <= in_half;
            moved_reg  <= 1'b0;
            pass_reg   <= '0;
            status_reg <= 1'b0;
        end
        if (cmd.add && full) begin
            status_reg <= 1'b1;
        end
        // latch mover bounds at the start of each pass
        if (cmd.prep) begin
            for (int a = 0; a < 3; a++) begin
                pmin_reg[a] <= PM_W'(wide_c(p_reg[a]) - wide_h(h_reg[a]));
                pmax_reg[a] <= PM_W'(wide_c(p_reg[a]) + wide_h(h_reg[a]));
            end
            addr_reg <= '0;
        end
        // advance the scan, hold separations of the first hit
        if (cmd.scan) begin
            addr_reg   <= addr_reg + IDX_W'(1);
            rd_idx_reg <= addr_reg;
            if (stat.hit) begin
                sep_reg  <= sep_now;
                best_reg <= sep_now[0];
                pick_reg <= '0;
                k_reg    <= SEL_W'(1);
            end
        end
        // one candidate a cycle, earlier direction wins ties
        if (cmd.pick) begin
            if (sep_reg[k_reg] < best_reg) begin
                best_reg <= sep_reg[k_reg];
                pick_reg <= k_reg;
            end
            k_reg <= k_reg + SEL_W'(1);
        end
        if (cmd.move) begin
            p_reg[ax] <= np;
            if (np != p_sel) begin
                moved_reg <= 1'b1;
            end
            pass_reg <= pass_reg + PASS_W'(1);
        end
        if (cmd.finish) begin
            m_tdata_reg <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, status_reg, 4'(pass_reg),
                            moved_reg, p_reg[2], p_reg[1], p_reg[0]};
        end
    end

    assign stat.command    = cmd_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.hit        = rd_vld_reg && (&ov);
    assign stat.last       = rd_vld_reg && ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.pick_last  = (k_reg == SEL_W'(SEP_N - 1));
    assign stat.pass_last  = (pass_reg == PASS_W'(MAX_PASSES - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/acpr_ctrl.sv =====
module acpr_ctrl import acpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  acpr_stat_t stat,
    output acpr_cmd_t  cmd
);

    acpr_state_t state_reg;
    acpr_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.command)
                    CMD_ADD: begin
                        cmd.add    = 1'b1;
                        state_next = ST_FINISH;
                    end
                    CMD_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    CMD_RESOLVE: begin
                        state_next = ST_PREP;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = stat.count_zero ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit) begin
                    state_next = ST_PICK;
                end else if (stat.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_PICK: begin
                cmd.pick = 1'b1;
                if (stat.pick_last) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                cmd.move   = 1'b1;
                state_next = stat.pass_last ? ST_FINISH : ST_PREP;
            end
            ST_FINISH: begin
                cmd.finish = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/aabb_collision_push_resolver_core.sv =====
// Box push-out resolver with a table of up to MAX_BOXES static boxes.
// Input channel s_*: one beat per command; s_tuser carries the command
// (add box, clear table, resolve mover), s_tdata the centre and half extents.
// Output channel m_*: exactly one beat per input beat, carrying the resolved
// or echoed centre, the pushed flag, the number of passes and the add status.
// Add, clear and unused commands go from dispatch straight to the result.
// Resolve runs passes of one table entry per cycle through the box memory's
// single read port: a pass scans up to the first overlapping entry, picks
// the push direction with the smallest separation and moves the centre;
// it stops after MAX_PASSES moves or when a pass finds no overlap.
// One command is in flight at a time; s_tready is high only between commands.
// A finished result sits in the output register, so the next command is
// accepted while the receiver stalls; its result waits until that beat goes.
// Reset empties the table and drops any pending result; memory contents are
// not cleared, as entries at or above the box count are never used.
module aabb_collision_push_resolver_core import acpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], half_x[126:96],
    // half_y[157:127], half_z[188:158], zero fill [191:189]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], pushed[96],
    // passes_used[100:97], status[101], zero fill [103:102]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    acpr_cmd_t  cmd;
    acpr_stat_t stat;

    acpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acpr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
